>>> rtl/pid_controller_antiwindup_unit_macros.svh
// Assertion macros shared by the PID controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PID_CONTROLLER_ANTIWINDUP_UNIT_MACROS_SVH
`define PID_CONTROLLER_ANTIWINDUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIDAW_ASSERT_IMPLIES(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIDAW_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/pidaw_pkg.sv
// Types, constants and register codes of the PID controller block.
// No dependencies; used by every module of the block.
package pidaw_pkg;

    localparam int W_VAL      = 32;
    localparam int W_DT       = 24;
    localparam int W_BOUND    = 31;
    localparam int W_IDX      = 3;
    localparam int W_ACC      = 34;
    localparam int DIV_NUM_W  = 58;
    localparam int DIV_STEPS  = DIV_NUM_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [W_IDX-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [W_IDX-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [W_IDX-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [W_IDX-1:0] REG_INTEGRAL_BOUND = 3'd3;
    localparam logic [W_IDX-1:0] REG_DRIVE_BOUND    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_INC,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_I,
        ST_ADD_I,
        ST_DIV_WAIT,
        ST_MUL_D,
        ST_ADD_D,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MSEL_INC,
        MSEL_P,
        MSEL_I,
        MSEL_D
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     err_commit;
        logic     div_start;
        logic     int_upd;
        logic     acc_clr;
        logic     acc_add;
        logic     deriv_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic dt_zero;
        logic div_done;
    } stat_t;

endpackage

>>> rtl/pidaw_div.sv
// Iterative unsigned divider, two quotient bits per cycle, for the derivative.
// Depends on pidaw_pkg for widths and step count.
module pidaw_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [pidaw_pkg::DIV_NUM_W-1:0]   dividend,
    input  logic [pidaw_pkg::W_DT-1:0]        divisor,
    output logic                              busy,
    output logic                              done,
    output logic [pidaw_pkg::DIV_NUM_W-1:0]   quotient
);

    logic [pidaw_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [pidaw_pkg::W_DT-1:0]      rem_reg, rem_next;
    logic [pidaw_pkg::W_DT-1:0]      dvs_reg;
    logic [pidaw_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [pidaw_pkg::W_DT:0] r1, r2;
    logic [pidaw_pkg::W_DT-1:0] rem_mid;
    logic ge1, ge2;

    always_comb begin
        r1      = {rem_reg, num_reg[pidaw_pkg::DIV_NUM_W-1]};
        ge1     = (r1 >= {1'b0, dvs_reg});
        rem_mid = ge1 ? pidaw_pkg::W_DT'(r1 - {1'b0, dvs_reg})
                      : r1[pidaw_pkg::W_DT-1:0];
        r2      = {rem_mid, num_reg[pidaw_pkg::DIV_NUM_W-2]};
        ge2     = (r2 >= {1'b0, dvs_reg});
        rem_next = ge2 ? pidaw_pkg::W_DT'(r2 - {1'b0, dvs_reg})
                       : r2[pidaw_pkg::W_DT-1:0];
        num_next = {num_reg[pidaw_pkg::DIV_NUM_W-3:0], ge1, ge2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == pidaw_pkg::DIV_CNT_W'(pidaw_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

>>> rtl/pidaw_ctrl.sv
// Sequencer of the PID controller: handshakes and datapath commands.
// Depends on pidaw_pkg and the assertion macro header.
`include "pid_controller_antiwindup_unit_macros.svh"

module pidaw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pidaw_pkg::stat_t  stat,
    output pidaw_pkg::cmd_t   cmd
);

    pidaw_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE:     if (s_valid) state_next = pidaw_pkg::ST_MUL_INC;
            pidaw_pkg::ST_MUL_INC:  state_next = pidaw_pkg::ST_INTEG;
            pidaw_pkg::ST_INTEG:    state_next = pidaw_pkg::ST_MUL_P;
            pidaw_pkg::ST_MUL_P:    state_next = pidaw_pkg::ST_MUL_I;
            pidaw_pkg::ST_MUL_I:    state_next = pidaw_pkg::ST_ADD_I;
            pidaw_pkg::ST_ADD_I:    state_next = pidaw_pkg::ST_DIV_WAIT;
            pidaw_pkg::ST_DIV_WAIT: begin
                if (stat.div_done || stat.dt_zero) state_next = pidaw_pkg::ST_MUL_D;
            end
            pidaw_pkg::ST_MUL_D:    state_next = pidaw_pkg::ST_ADD_D;
            pidaw_pkg::ST_ADD_D:    state_next = pidaw_pkg::ST_FINISH;
            pidaw_pkg::ST_FINISH:   if (out_free) state_next = pidaw_pkg::ST_IDLE;
            default:                state_next = pidaw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = pidaw_pkg::MSEL_INC;
        s_ready     = 1'b0;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            pidaw_pkg::ST_MUL_INC: begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = pidaw_pkg::MSEL_INC;
                cmd.err_commit = 1'b1;
                cmd.div_start  = !stat.dt_zero;
            end
            pidaw_pkg::ST_INTEG: cmd.int_upd = 1'b1;
            pidaw_pkg::ST_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidaw_pkg::MSEL_P;
            end
            pidaw_pkg::ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidaw_pkg::MSEL_I;
                cmd.acc_clr = 1'b1;
            end
            pidaw_pkg::ST_ADD_I:    cmd.acc_add = 1'b1;
            pidaw_pkg::ST_DIV_WAIT: cmd.deriv_load = stat.div_done || stat.dt_zero;
            pidaw_pkg::ST_MUL_D: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidaw_pkg::MSEL_D;
            end
            pidaw_pkg::ST_ADD_D:    cmd.acc_add = 1'b1;
            pidaw_pkg::ST_FINISH:   cmd.out_load = out_free;
            default: ;
        endcase
    end

    // Output register: hold until taken, refill only when free.
    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.out_load) m_valid_next = 1'b1;
        else if (m_ready)          m_valid_next = 1'b0;
        else                       m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pidaw_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `PIDAW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted while a transaction is in progress")
    `PIDAW_ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready, "pending result overwritten")
    `PIDAW_ASSERT_IMPLIES(a_single_start, aclk, aresetn, cmd.div_start, !stat.dt_zero && state_reg == pidaw_pkg::ST_MUL_INC, "divider started out of sequence")

endmodule

>>> rtl/pidaw_dpath.sv
// Datapath of the PID controller: config registers, shared multiplier,
// integral and drive clamps, derivative divider. Depends on pidaw_pkg,
// pidaw_div and the assertion macro header.
`include "pid_controller_antiwindup_unit_macros.svh"

module pidaw_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pidaw_pkg::cmd_t                       cmd,
    output pidaw_pkg::stat_t                      stat,
    input  logic signed [pidaw_pkg::W_VAL-1:0]    s_target,
    input  logic signed [pidaw_pkg::W_VAL-1:0]    s_measured,
    input  logic        [pidaw_pkg::W_DT-1:0]     s_elapsed,
    input  logic                                  cfg_wr,
    input  logic        [pidaw_pkg::W_IDX-1:0]    cfg_index,
    input  logic        [pidaw_pkg::W_VAL-1:0]    cfg_data,
    output logic signed [pidaw_pkg::W_VAL-1:0]    m_drive
);

    localparam logic signed [47:0] T_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] T_MIN = -48'sh0000_8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [pidaw_pkg::W_BOUND-1:0] ibound_reg, dbound_reg;
    logic signed [31:0] integral_reg, integral_next;
    logic signed [31:0] last_err_reg;
    logic signed [31:0] err_reg, err_next;
    logic [pidaw_pkg::W_DT-1:0] dt_reg;
    logic signed [63:0] prod_reg;
    logic signed [pidaw_pkg::W_ACC-1:0] acc_reg;
    logic signed [31:0] deriv_reg, deriv_next;
    logic deriv_neg_reg;
    logic signed [31:0] drive_reg, drive_next;

    logic signed [32:0] in_diff, err_diff;
    logic [32:0] diff_mag;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_full;
    logic signed [63:0] inc_full, term_full;
    logic signed [33:0] int_sum, ibound_s, dbound_s;
    logic signed [47:0] term48;
    logic signed [31:0] term;
    logic signed [31:0] ibound32, dbound32;
    logic [pidaw_pkg::DIV_NUM_W-1:0] div_quot;
    logic div_busy, div_done;
    logic ovf_pos, ovf_neg;

    // Configuration writes; out-of-range indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            ibound_reg <= '0;
            dbound_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                pidaw_pkg::REG_GAIN_P:         gain_p_reg <= cfg_data;
                pidaw_pkg::REG_GAIN_I:         gain_i_reg <= cfg_data;
                pidaw_pkg::REG_GAIN_D:         gain_d_reg <= cfg_data;
                pidaw_pkg::REG_INTEGRAL_BOUND: ibound_reg <= cfg_data[pidaw_pkg::W_BOUND-1:0];
                pidaw_pkg::REG_DRIVE_BOUND:    dbound_reg <= cfg_data[pidaw_pkg::W_BOUND-1:0];
                default: ;
            endcase
        end
    end

    // Error with saturation to 32 bits.
    always_comb begin
        in_diff = 33'(s_target) - 33'(s_measured);
        priority if (in_diff > 33'sh0_7FFF_FFFF)   err_next = S32_MAX;
        else if (in_diff < -33'sh0_8000_0000)      err_next = S32_MIN;
        else                                       err_next = in_diff[31:0];
    end

    // Derivative dividend: |error - last error| scaled by 2^24.
    assign err_diff = 33'(err_reg) - 33'(last_err_reg);
    assign diff_mag = err_diff[32] ? 33'(-err_diff) : 33'(err_diff);

    pidaw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({1'b0, diff_mag, {pidaw_pkg::W_DT{1'b0}}}),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Shared multiplier.
    always_comb begin
        mul_a = err_reg;
        mul_b = 32'({8'b0, dt_reg});
        unique case (cmd.mul_sel)
            pidaw_pkg::MSEL_INC: begin
                mul_a = err_reg;
                mul_b = 32'({8'b0, dt_reg});
            end
            pidaw_pkg::MSEL_P: begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
            pidaw_pkg::MSEL_I: begin
                mul_a = gain_i_reg;
                mul_b = integral_reg;
            end
            pidaw_pkg::MSEL_D: begin
                mul_a = gain_d_reg;
                mul_b = deriv_reg;
            end
            default: ;
        endcase
    end
    assign mul_full = mul_a * mul_b;

    // Integral: round Q16.40 to Q16.16, add, clamp.
    assign ibound_s = 34'({1'b0, ibound_reg});
    always_comb begin
        inc_full = (prod_reg + 64'sd8388608) >>> 24;
        int_sum  = 34'(integral_reg) + inc_full[33:0];
        priority if (int_sum > ibound_s)  integral_next = ibound_s[31:0];
        else if (int_sum < -ibound_s)     integral_next = 32'(-ibound_s);
        else                              integral_next = int_sum[31:0];
    end

    // Gain term: round Q32.32 to Q16.16 and saturate.
    always_comb begin
        term_full = (prod_reg + 64'sd32768) >>> 16;
        term48    = term_full[47:0];
        priority if (term48 > T_MAX)  term = S32_MAX;
        else if (term48 < T_MIN)      term = S32_MIN;
        else                          term = term48[31:0];
    end

    // Derivative from the unsigned quotient and the sign of the difference.
    always_comb begin
        ovf_pos = |div_quot[pidaw_pkg::DIV_NUM_W-1:31];
        ovf_neg = (|div_quot[pidaw_pkg::DIV_NUM_W-1:32]) ||
                  (div_quot[31] && (|div_quot[30:0]));
        priority if (stat.dt_zero)    deriv_next = '0;
        else if (!deriv_neg_reg)      deriv_next = ovf_pos ? S32_MAX : div_quot[31:0];
        else                          deriv_next = ovf_neg ? S32_MIN : -div_quot[31:0];
    end

    assign dbound_s = 34'({1'b0, dbound_reg});
    always_comb begin
        priority if (acc_reg > dbound_s)  drive_next = dbound_s[31:0];
        else if (acc_reg < -dbound_s)     drive_next = 32'(-dbound_s);
        else                              drive_next = acc_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            last_err_reg <= '0;
        end else begin
            if (cmd.int_upd)    integral_reg <= integral_next;
            if (cmd.err_commit) last_err_reg <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            err_reg <= err_next;
            dt_reg  <= s_elapsed;
        end
        if (cmd.err_commit) deriv_neg_reg <= err_diff[32];
        if (cmd.mul_en)     prod_reg <= mul_full;
        if (cmd.acc_clr)    acc_reg <= pidaw_pkg::W_ACC'(term);
        else if (cmd.acc_add) acc_reg <= acc_reg + pidaw_pkg::W_ACC'(term);
        if (cmd.deriv_load) deriv_reg <= deriv_next;
        if (cmd.out_load)   drive_reg <= drive_next;
    end

    assign stat.dt_zero  = (dt_reg == '0);
    assign stat.div_done = div_done && !div_busy;
    assign m_drive       = drive_reg;

    assign ibound32 = 32'({1'b0, ibound_reg});
    assign dbound32 = 32'({1'b0, dbound_reg});

    `PIDAW_ASSERT_NEXT(a_integral_clamped, aclk, aresetn, cmd.int_upd, integral_reg <= ibound32 && integral_reg >= -ibound32, "integral outside its bound")
    `PIDAW_ASSERT_NEXT(a_drive_clamped, aclk, aresetn, cmd.out_load, drive_reg <= dbound32 && drive_reg >= -dbound32, "drive outside its bound")

endmodule

>>> rtl/pid_controller_antiwindup_unit.sv
// PID controller with integral clamp: top level joining sequencer and datapath.
// Depends on pidaw_pkg, pidaw_ctrl and pidaw_dpath.
//
// Usage:
//   Input channel s_*: one transaction carries target, measured (signed
//   Q16.16) and elapsed (unsigned Q0.24 s). Result channel m_*: one drive
//   value (signed Q16.16) per input transaction, in order.
//   Configuration channel cfg_*: index 0..4 selects gain_p, gain_i, gain_d,
//   integral_bound, drive_bound; cfg_ready is always high, other indexes
//   are dropped. Write only while no transaction is in flight.
//   The sequencer steps from input accept to m_valid; when elapsed is
//   nonzero it waits in ST_DIV_WAIT for the two-bit-per-cycle divider
//   that forms the derivative, skipped when elapsed is zero. One multiplier
//   is shared by the four products. A new input is taken in the cycle
//   after the result is loaded: one transaction in the sequencer at a time.
//   Reset (aresetn low, synchronous) clears gains, bounds, integral and
//   last error to zero and drops any pending result.
//   When m_ready is low the finished result holds in the output register;
//   the next input may already be accepted and is held at its last step
//   until the register frees.
module pid_controller_antiwindup_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [pidaw_pkg::W_VAL-1:0]    s_target,
    input  logic signed [pidaw_pkg::W_VAL-1:0]    s_measured,
    input  logic        [pidaw_pkg::W_DT-1:0]     s_elapsed,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pidaw_pkg::W_VAL-1:0]    m_drive,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [pidaw_pkg::W_IDX-1:0]    cfg_index,
    input  logic        [pidaw_pkg::W_VAL-1:0]    cfg_data
);

    pidaw_pkg::cmd_t  cmd;
    pidaw_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    pidaw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pidaw_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_target   (s_target),
        .s_measured (s_measured),
        .s_elapsed  (s_elapsed),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_drive    (m_drive)
    );

endmodule
